>>> sv/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants for the camera frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

    // input opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // frame status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SYNC = 3'd1;
    localparam logic [2:0] ST_BAD_LEN  = 3'd2;
    localparam logic [2:0] ST_BAD_SUM  = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    // config register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    // protocol and reset constants
    localparam logic [7:0]  SYNC_BYTE     = 8'hAA;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [15:0] MAX_LEN_RESET = 16'd6000;

    // one input request
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } item_t;

    // one result request
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_offset;
        logic [2:0]  status;
        logic [15:0] frame_length;
    } result_t;

endpackage

>>> sv/cfd_core.sv
// ----------------------------------------------------------------------------
// cfd_core
// Frame parser state, config registers and the per-item result logic.
// ----------------------------------------------------------------------------
module cfd_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data,
    input  cfd_pkg::item_t   item,
    input  logic             advance,
    output logic             has_result,
    output cfd_pkg::result_t result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    phase_t      phase_reg,       phase_next;
    logic [1:0]  hdr_count_reg,   hdr_count_next;
    logic [7:0]  sync_seen_reg,   sync_seen_next;
    logic [15:0] decl_len_reg,    decl_len_next;
    logic [15:0] offset_reg,      offset_next;
    logic [7:0]  xor_reg,         xor_next;
    logic [15:0] elapsed_reg,     elapsed_next;
    logic [15:0] timeout_reg;
    logic [15:0] max_len_reg;

    logic [15:0] offset_inc;
    logic [15:0] elapsed_inc;
    logic [15:0] len_full;

    assign offset_inc  = offset_reg + 16'd1;
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign len_full    = {decl_len_reg[15:8], item.rx_byte};

    // next state and result for the item in the input register
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_count_next = hdr_count_reg;
        sync_seen_next = sync_seen_reg;
        decl_len_next  = decl_len_reg;
        offset_next    = offset_reg;
        xor_next       = xor_reg;
        elapsed_next   = elapsed_reg;
        has_result     = 1'b0;
        result         = '0;
        result.kind    = cfd_pkg::KIND_STATUS;

        case (item.opcode)
            cfd_pkg::OP_START:
            begin
                phase_next     = PH_HEADER;
                hdr_count_next = 2'd0;
                sync_seen_next = 8'd0;
                decl_len_next  = 16'd0;
                offset_next    = 16'd0;
                xor_next       = 8'd0;
                elapsed_next   = 16'd0;
            end
            cfd_pkg::OP_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > timeout_reg)
                    begin
                        has_result    = 1'b1;
                        result.status = cfd_pkg::ST_TIMEOUT;
                        phase_next    = PH_IDLE;
                    end
                end
            end
            cfd_pkg::OP_BYTE:
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        xor_next = xor_reg ^ item.rx_byte;
                        case (hdr_count_reg)
                            2'd0:
                            begin
                                sync_seen_next = item.rx_byte;
                                hdr_count_next = 2'd1;
                            end
                            2'd1:
                            begin
                                decl_len_next  = {item.rx_byte, 8'd0};
                                hdr_count_next = 2'd2;
                            end
                            default:
                            begin
                                decl_len_next  = len_full;
                                hdr_count_next = 2'd0;
                                if (sync_seen_reg != cfd_pkg::SYNC_BYTE)
                                begin
                                    has_result    = 1'b1;
                                    result.status = cfd_pkg::ST_BAD_SYNC;
                                    phase_next    = PH_IDLE;
                                end
                                else if (len_full == 16'd0 || len_full > max_len_reg)
                                begin
                                    has_result    = 1'b1;
                                    result.status = cfd_pkg::ST_BAD_LEN;
                                    phase_next    = PH_IDLE;
                                end
                                else
                                begin
                                    offset_next = 16'd0;
                                    phase_next  = PH_PAYLOAD;
                                end
                            end
                        endcase
                    end
                    PH_PAYLOAD:
                    begin
                        has_result         = 1'b1;
                        result.kind        = cfd_pkg::KIND_DATA;
                        result.data_byte   = item.rx_byte;
                        result.byte_offset = offset_reg;
                        xor_next           = xor_reg ^ item.rx_byte;
                        offset_next        = offset_inc;
                        if (offset_inc == decl_len_reg)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        has_result = 1'b1;
                        phase_next = PH_IDLE;
                        if (item.rx_byte != xor_reg)
                        begin
                            result.status = cfd_pkg::ST_BAD_SUM;
                        end
                        else
                        begin
                            result.status       = cfd_pkg::ST_OK;
                            result.frame_length = decl_len_reg;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // parser state, updated when the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hdr_count_reg <= 2'd0;
            sync_seen_reg <= 8'd0;
            decl_len_reg  <= 16'd0;
            offset_reg    <= 16'd0;
            xor_reg       <= 8'd0;
            elapsed_reg   <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            hdr_count_reg <= hdr_count_next;
            sync_seen_reg <= sync_seen_next;
            decl_len_reg  <= decl_len_next;
            offset_reg    <= offset_next;
            xor_reg       <= xor_next;
            elapsed_reg   <= elapsed_next;
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= cfd_pkg::TIMEOUT_RESET;
            max_len_reg <= cfd_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == cfd_pkg::CFG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
            else
            begin
                max_len_reg <= cfg_data;
            end
        end
    end

endmodule

>>> sv/cfd_out_stage.sv
// ----------------------------------------------------------------------------
// cfd_out_stage
// Result register that holds one result request until the sink takes it.
// ----------------------------------------------------------------------------
module cfd_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  cfd_pkg::result_t load_data,
    input  logic             m_tready,
    output logic             free,
    output logic             m_tvalid,
    output cfd_pkg::result_t m_data
);

    logic             valid_reg;
    cfd_pkg::result_t data_reg;

    // slot can take a new result when empty or draining this cycle
    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_data   = data_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

>>> sv/camera_frame_deframer.sv
// ----------------------------------------------------------------------------
// camera_frame_deframer
// Parses sync, length, payload and xor checksum of a camera frame, passing
// payload bytes out with their offsets and ending with one status result.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          content
//  s_axis    in   s_tvalid/s_tready  tuser opcode, tdata rx_byte
//  m_axis    out  m_tvalid/m_tready  tuser kind, tdata result fields
//  cfg       in   cfg_we             cfg_index, cfg_data (16 bit)
//
//  One request per clock while the sink does not stall; m_tvalid follows
//  acceptance via input register, then result register after the parser logic.
//  Reset clears the parser to idle and loads timeout 3000 and max length 6000.
//  A stalled sink holds the result register; an item with no result still
//  waits for a free result slot, and s_tready drops once the input register
//  is full and cannot drain.
// ----------------------------------------------------------------------------
module camera_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] data_byte, [23:8] byte_offset,
                                   // [26:24] status, [42:27] frame_length, zero fill
    output logic [0:0]  m_tuser    // [0] kind
);

    logic             in_valid_reg;
    cfd_pkg::item_t   in_item_reg;
    logic             in_accept;
    logic             advance;
    logic             has_result;
    logic             out_free;
    cfd_pkg::result_t result;
    cfd_pkg::result_t out_data;

    // input register handshake
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.opcode  <= s_tuser;
            in_item_reg.rx_byte <= s_tdata;
        end
    end

    // parser
    cfd_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item       (in_item_reg),
        .advance    (advance),
        .has_result (has_result),
        .result     (result)
    );

    // result register
    cfd_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .load_data (result),
        .m_tready  (m_tready),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_data    (out_data)
    );

    // pack output fields
    assign m_tuser = out_data.kind;
    assign m_tdata = {5'd0, out_data.frame_length, out_data.status,
                      out_data.byte_offset, out_data.data_byte};

endmodule
